### rtl/gpsf_pkg.sv
// ----------------------------------------------------------------------------
// gpsf_pkg: shared constants, types and tables of the Gaussian PSF unit
// Register indexes, divider geometry, the exp() bit table and word types.
// ----------------------------------------------------------------------------
package gpsf_pkg;

    // configuration register indexes
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_BACKGROUND = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_AMPLITUDE  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CENTER_X   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_CENTER_Y   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SIGMA      = 3'd4;

    localparam logic [31:0] AMPLITUDE_RESET = 32'h0001_0000;
    localparam logic [15:0] SIGMA_RESET     = 16'h0100;

    // exponent argument t is Q16 and below 2^20
    localparam int ExpBits     = 20;
    localparam int SeriesTerms = 24;

    // divider for t = (d2 * 2^16 + r2) / (2 * r2)
    localparam int TDivNW = 54;
    localparam int TDivDW = 33;
    localparam int TDivQW = ExpBits;
    // dividers for the centre gradients, divisor r2
    localparam int GDivNW = 64;
    localparam int GDivDW = 32;
    localparam int GDivQW = 32;
    // divider for the sigma gradient, divisor sigma * 256
    localparam int SDivNW = 53;
    localparam int SDivDW = 24;

    typedef struct packed {
        logic [23:0] dxm;
        logic        dxneg;
        logic [23:0] dym;
        logic        dyneg;
    } dist_t;

    typedef struct packed {
        logic [31:0] mv;
        logic        mvsat;
        logic [16:0] damp;
        logic        dxneg;
        logic        dyneg;
    } fin_t;

    typedef struct packed {
        logic [31:0] model_value;
        logic [16:0] deriv_amplitude;
        logic [31:0] deriv_center_x;
        logic [31:0] deriv_center_y;
        logic [31:0] deriv_sigma;
        logic        saturated;
    } res_t;

    // exp(-2^(B-16)) in Q0.30, evaluated at elaboration
    function automatic logic [63:0] exp_rom(input int B);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        x    = 64'd1 << ((B <= 16) ? B : 16);
        sum  = 64'sh100_0000_0000;
        term = 64'h100_0000_0000;
        for (int n = 1; n <= SeriesTerms; n++) begin
            term = ((term * x) >> 16) / 64'(n);
            if ((n & 1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        r = (64'(sum) + 64'd512) >> 10;
        for (int k = 17; k <= B; k++) begin
            r = (r * r + (64'd1 << 29)) >> 30;
        end
        return r;
    endfunction

endpackage

### rtl/gpsf_div.sv
// ----------------------------------------------------------------------------
// gpsf_div: pipelined restoring divider
// One quotient bit per stage, QW stages; flags a quotient of 2^QW or more.
// ----------------------------------------------------------------------------
module gpsf_div
    import gpsf_pkg::*;
#(
    parameter int NW = TDivNW,
    parameter int DW = TDivDW,
    parameter int QW = TDivQW
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic          ovf
);

    localparam int TW = NW - QW;
    localparam int CW = (TW > DW) ? TW : DW;

    logic [CW-1:0] top_ext;
    logic [CW-1:0] den_ext;
    logic          ovf_in;

    logic [DW-1:0] rem_src [QW];
    logic [QW-1:0] low_src [QW];
    logic [QW-1:0] quo_src [QW];
    logic [DW-1:0] den_src [QW];
    logic          ovf_src [QW];

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic          ovf_reg [QW];

    assign top_ext = CW'(num[NW-1:QW]);
    assign den_ext = CW'(den);
    assign ovf_in  = (top_ext >= den_ext);

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0] r;
        logic [DW:0] diff;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_src[k] = ovf_in ? '0 : top_ext[DW-1:0];
            assign low_src[k] = num[QW-1:0];
            assign quo_src[k] = '0;
            assign den_src[k] = den;
            assign ovf_src[k] = ovf_in;
        end else begin : g_next
            assign rem_src[k] = rem_reg[k-1];
            assign low_src[k] = low_reg[k-1];
            assign quo_src[k] = quo_reg[k-1];
            assign den_src[k] = den_reg[k-1];
            assign ovf_src[k] = ovf_reg[k-1];
        end

        assign r    = {rem_src[k], low_src[k][QW-1]};
        assign diff = r - {1'b0, den_src[k]};
        assign ge   = (r >= {1'b0, den_src[k]});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DW-1:0] : r[DW-1:0];
                low_reg[k] <= {low_src[k][QW-2:0], 1'b0};
                quo_reg[k] <= {quo_src[k][QW-2:0], ge};
                den_reg[k] <= den_src[k];
                ovf_reg[k] <= ovf_src[k];
            end
        end
    end

    assign quo = quo_reg[QW-1];
    assign ovf = ovf_reg[QW-1];

endmodule

### rtl/gaussian_psf_value_and_gradient_unit.sv
// ----------------------------------------------------------------------------
// gaussian_psf_value_and_gradient_unit: Gaussian star model and its gradient
// Per pixel: background + A*E, E = exp(-d^2/(2 sigma^2)), d/dA, d/dcx,
// d/dcy and d/dsigma, all fixed point with saturation.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------
//  input    | s_pixel_col, s_pixel_row                | s_valid / s_ready
//  result   | m_model_value, m_deriv_*, m_saturated   | m_valid / m_ready
//  config   | cfg_wr_index, cfg_wr_data               | cfg_wr_en, no wait
//
//  Throughput: one word per cycle while the skid is empty. A word runs from
//  accept to m_valid through three chained unit chains: the 20-stage
//  divider for the exponent argument, the 20-stage exp() multiplier chain
//  (one table constant per argument bit) and the 32-stage gradient dividers.
//  Reset clears the configuration to its defaults and drops all words.
//  Stalls: a two-word output (register plus skid) frees s_ready from m_ready;
//  the whole pipe holds only while the skid word waits.
//
module gaussian_psf_value_and_gradient_unit
    import gpsf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_wr_index,
    input  logic [31:0]        cfg_wr_data,
    // pixel words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_pixel_col,
    input  logic [15:0]        s_pixel_row,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_model_value,
    output logic [16:0]        m_deriv_amplitude,
    output logic [31:0]        m_deriv_center_x,
    output logic [31:0]        m_deriv_center_y,
    output logic [31:0]        m_deriv_sigma,
    output logic               m_saturated
);

    // stage bookkeeping: valid index of each checkpoint
    localparam int TDivEnd = 3 + TDivQW;        // t available
    localparam int ExpEnd  = TDivEnd + ExpBits; // E available
    localparam int NumIdx  = ExpEnd + 3;        // divider numerators
    localparam int NStg    = NumIdx + GDivQW + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] bg_reg, amp_reg;
    logic [23:0] cx_reg, cy_reg;
    logic [15:0] sig_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_reg  <= '0;
            amp_reg <= AMPLITUDE_RESET;
            cx_reg  <= '0;
            cy_reg  <= '0;
            sig_reg <= SIGMA_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_BACKGROUND: bg_reg  <= cfg_wr_data;
                CFG_AMPLITUDE:  amp_reg <= cfg_wr_data;
                CFG_CENTER_X:   cx_reg  <= cfg_wr_data[23:0];
                CFG_CENTER_Y:   cy_reg  <= cfg_wr_data[23:0];
                CFG_SIGMA:      sig_reg <= cfg_wr_data[15:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // derived constants, refreshed every cycle; after a sigma write r2x24 settles
    // through r2_reg and then r2x24_reg, in time for the first word behind it
    logic [15:0] seff;
    logic [15:0] seff_reg;
    logic [31:0] r2_reg;
    logic [36:0] r2x24_reg;
    logic        amp_neg;
    logic [31:0] amp_mag;

    assign seff = (sig_reg == '0) ? 16'd1 : sig_reg;

    always_ff @(posedge aclk) begin
        seff_reg  <= seff;
        r2_reg    <= 32'(seff) * 32'(seff);
        r2x24_reg <= 37'(r2_reg) * 37'd24;
    end

    assign amp_neg = amp_reg[31];
    assign amp_mag = amp_neg ? (32'd0 - amp_reg) : amp_reg;

    // ------------------------------------------------------------------
    // flow control: advance the pipe unless the skid holds a word
    // ------------------------------------------------------------------
    logic en;
    logic skid_valid_reg, skid_valid_next;
    logic m_valid_reg, m_valid_next;
    logic vld_reg [NStg];

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NStg; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < NStg; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 1..4: offsets, squares, d2 and the t numerator
    // ------------------------------------------------------------------
    logic [23:0] colq, rowq;
    dist_t       s1_dist_reg, s2_dist_reg, s3_dist_reg, s4_dist_reg;
    logic [47:0] dx2_reg, dy2_reg;
    logic [48:0] d2_reg;
    logic        near_reg, s4_near_reg;
    logic [TDivNW-1:0] tnum_reg;

    assign colq = {s_pixel_col, 8'h00};
    assign rowq = {s_pixel_row, 8'h00};

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_dist_reg.dxneg <= (colq < cx_reg);
            s1_dist_reg.dxm   <= (colq < cx_reg) ? (cx_reg - colq) : (colq - cx_reg);
            s1_dist_reg.dyneg <= (rowq < cy_reg);
            s1_dist_reg.dym   <= (rowq < cy_reg) ? (cy_reg - rowq) : (rowq - cy_reg);

            dx2_reg     <= 48'(s1_dist_reg.dxm) * 48'(s1_dist_reg.dxm);
            dy2_reg     <= 48'(s1_dist_reg.dym) * 48'(s1_dist_reg.dym);
            s2_dist_reg <= s1_dist_reg;

            d2_reg      <= 49'(dx2_reg) + 49'(dy2_reg);
            near_reg    <= ((49'(dx2_reg) + 49'(dy2_reg)) < 49'(r2x24_reg));
            s3_dist_reg <= s2_dist_reg;

            // past the underflow limit feed zero so t comes out zero
            tnum_reg    <= near_reg ? (TDivNW'({d2_reg[36:0], 16'h0000}) + TDivNW'(r2_reg))
                                    : '0;
            s4_near_reg <= near_reg;
            s4_dist_reg <= s3_dist_reg;
        end
    end

    // ------------------------------------------------------------------
    // t divider with the side data alongside
    // ------------------------------------------------------------------
    logic [TDivQW-1:0] t_quo;
    logic              t_ovf;
    dist_t             td_dist_reg [TDivQW];
    logic              td_near_reg [TDivQW];

    gpsf_div #(
        .NW (TDivNW),
        .DW (TDivDW),
        .QW (TDivQW)
    ) u_tdiv (
        .aclk (aclk),
        .en   (en),
        .num  (tnum_reg),
        .den  ({r2_reg, 1'b0}),
        .quo  (t_quo),
        .ovf  (t_ovf)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            td_dist_reg[0] <= s4_dist_reg;
            td_near_reg[0] <= s4_near_reg;
            for (int i = 1; i < TDivQW; i++) begin
                td_dist_reg[i] <= td_dist_reg[i-1];
                td_near_reg[i] <= td_near_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // exp(-t): one table constant per bit of t, one multiply per stage
    // ------------------------------------------------------------------
    logic [30:0]        acc_reg  [ExpBits];
    logic [ExpBits-1:0] et_reg   [ExpBits];
    dist_t              ed_dist_reg [ExpBits];

    for (genvar j = 0; j < ExpBits; j++) begin : g_exp
        localparam logic [29:0] K = 30'(exp_rom(j));
        logic [30:0]        acc_in;
        logic [ExpBits-1:0] t_in;
        dist_t              dist_in;
        logic [61:0]        prod;

        if (j == 0) begin : g_first
            assign acc_in  = td_near_reg[TDivQW-1] ? 31'h4000_0000 : '0;
            assign t_in    = t_quo;
            assign dist_in = td_dist_reg[TDivQW-1];
        end else begin : g_next
            assign acc_in  = acc_reg[j-1];
            assign t_in    = et_reg[j-1];
            assign dist_in = ed_dist_reg[j-1];
        end

        assign prod = 62'(acc_in) * 62'(K) + (62'd1 << 29);

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[j]     <= t_in[j] ? prod[60:30] : acc_in;
                et_reg[j]      <= t_in;
                ed_dist_reg[j] <= dist_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // amplitude product, model value and divider numerators
    // ------------------------------------------------------------------
    logic [62:0]        pm_prod;
    logic [31:0]        pm_reg;
    logic [16:0]        damp_reg;
    logic [ExpBits-1:0] p_t_reg;
    dist_t              p_dist_reg;

    logic [55:0]        px_reg, py_reg;
    logic [51:0]        pt_reg;
    logic [33:0]        mv_sum;
    fin_t               q_fin_reg, n_fin_reg;
    logic [31:0]        mv_sat;
    logic               mv_flag;

    logic [GDivNW-1:0]  nx_reg, ny_reg;
    logic [SDivNW-1:0]  ns_reg;

    assign pm_prod = 63'(amp_mag) * 63'(acc_reg[ExpBits-1]) + (63'd1 << 29);

    assign mv_sum = {{2{bg_reg[31]}}, bg_reg}
                  + (amp_neg ? (34'd0 - {2'b00, pm_reg}) : {2'b00, pm_reg});

    always_comb begin
        mv_flag = 1'b0;
        mv_sat  = mv_sum[31:0];
        if (!mv_sum[33] && (mv_sum[32:31] != 2'b00)) begin
            mv_flag = 1'b1;
            mv_sat  = 32'h7FFF_FFFF;
        end else if (mv_sum[33] && (mv_sum[32:31] != 2'b11)) begin
            mv_flag = 1'b1;
            mv_sat  = 32'h8000_0000;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pm_reg     <= pm_prod[61:30];
            damp_reg   <= 17'((32'(acc_reg[ExpBits-1]) + 32'd8192) >> 14);
            p_t_reg    <= et_reg[ExpBits-1];
            p_dist_reg <= ed_dist_reg[ExpBits-1];

            px_reg          <= 56'(pm_reg) * 56'(p_dist_reg.dxm);
            py_reg          <= 56'(pm_reg) * 56'(p_dist_reg.dym);
            pt_reg          <= 52'(pm_reg) * 52'(p_t_reg);
            q_fin_reg.mv    <= mv_sat;
            q_fin_reg.mvsat <= mv_flag;
            q_fin_reg.damp  <= damp_reg;
            q_fin_reg.dxneg <= p_dist_reg.dxneg;
            q_fin_reg.dyneg <= p_dist_reg.dyneg;

            nx_reg    <= {px_reg, 8'h00} + GDivNW'(r2_reg[31:1]);
            ny_reg    <= {py_reg, 8'h00} + GDivNW'(r2_reg[31:1]);
            ns_reg    <= SDivNW'({pt_reg, 1'b0}) + SDivNW'({seff_reg, 7'h00});
            n_fin_reg <= q_fin_reg;
        end
    end

    // ------------------------------------------------------------------
    // gradient dividers
    // ------------------------------------------------------------------
    logic [GDivQW-1:0] qx, qy, qs;
    logic              ox, oy, os;
    fin_t              gd_fin_reg [GDivQW];

    gpsf_div #(
        .NW (GDivNW),
        .DW (GDivDW),
        .QW (GDivQW)
    ) u_xdiv (
        .aclk (aclk),
        .en   (en),
        .num  (nx_reg),
        .den  (r2_reg),
        .quo  (qx),
        .ovf  (ox)
    );

    gpsf_div #(
        .NW (GDivNW),
        .DW (GDivDW),
        .QW (GDivQW)
    ) u_ydiv (
        .aclk (aclk),
        .en   (en),
        .num  (ny_reg),
        .den  (r2_reg),
        .quo  (qy),
        .ovf  (oy)
    );

    gpsf_div #(
        .NW (SDivNW),
        .DW (SDivDW),
        .QW (GDivQW)
    ) u_sdiv (
        .aclk (aclk),
        .en   (en),
        .num  (ns_reg),
        .den  ({seff_reg, 8'h00}),
        .quo  (qs),
        .ovf  (os)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            gd_fin_reg[0] <= n_fin_reg;
            for (int i = 1; i < GDivQW; i++) begin
                gd_fin_reg[i] <= gd_fin_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // signed saturation of the gradients, result assembly
    // ------------------------------------------------------------------
    // returns {clamped, value}
    function automatic logic [32:0] sat_mag(input logic neg, input logic ovf,
                                            input logic [31:0] q);
        logic [32:0] res;
        if (!neg) begin
            res = (ovf || q[31]) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, q};
        end else begin
            res = (ovf || (q > 32'h8000_0000)) ? {1'b1, 32'h8000_0000}
                                                : {1'b0, 32'd0 - q};
        end
        return res;
    endfunction

    fin_t        fin;
    logic [32:0] sx, sy, ss;
    res_t        res_new;

    assign fin = gd_fin_reg[GDivQW-1];
    assign sx  = sat_mag(amp_neg ^ fin.dxneg, ox, qx);
    assign sy  = sat_mag(amp_neg ^ fin.dyneg, oy, qy);
    assign ss  = sat_mag(amp_neg, os, qs);

    always_comb begin
        res_new.model_value     = fin.mv;
        res_new.deriv_amplitude = fin.damp;
        res_new.deriv_center_x  = sx[31:0];
        res_new.deriv_center_y  = sy[31:0];
        res_new.deriv_sigma     = ss[31:0];
        res_new.saturated       = fin.mvsat | sx[32] | sy[32] | ss[32];
    end

    // ------------------------------------------------------------------
    // output register and skid
    // ------------------------------------------------------------------
    res_t out_reg, skid_reg;
    logic out_load_new, out_load_skid, skid_load;

    always_comb begin
        out_load_new    = en && vld_reg[NStg-1] && (!m_valid_reg || m_ready);
        skid_load       = en && vld_reg[NStg-1] && m_valid_reg && !m_ready;
        out_load_skid   = skid_valid_reg && m_ready;
        m_valid_next    = out_load_new || out_load_skid || (m_valid_reg && !m_ready);
        skid_valid_next = skid_load || (skid_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load_skid) begin
            out_reg <= skid_reg;
        end else if (out_load_new) begin
            out_reg <= res_new;
        end
        if (skid_load) begin
            skid_reg <= res_new;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_model_value     = out_reg.model_value;
    assign m_deriv_amplitude = out_reg.deriv_amplitude;
    assign m_deriv_center_x  = out_reg.deriv_center_x;
    assign m_deriv_center_y  = out_reg.deriv_center_y;
    assign m_deriv_sigma     = out_reg.deriv_sigma;
    assign m_saturated       = out_reg.saturated;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the skid only fills behind a waiting output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid word without output word");

    // the exponent argument always fits its width
    a_t_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[TDivEnd] |-> !t_ovf)
        else $error("exponent argument overflow");

    // E never exceeds one
    a_damp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_deriv_amplitude <= 17'h1_0000))
        else $error("deriv_amplitude above one");

    // a clamp flag means some field sits on a rail
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_saturated) |->
            (m_model_value == 32'h7FFF_FFFF || m_model_value == 32'h8000_0000 ||
             m_deriv_center_x == 32'h7FFF_FFFF || m_deriv_center_x == 32'h8000_0000 ||
             m_deriv_center_y == 32'h7FFF_FFFF || m_deriv_center_y == 32'h8000_0000 ||
             m_deriv_sigma == 32'h7FFF_FFFF || m_deriv_sigma == 32'h8000_0000))
        else $error("saturated flag without clamped field");

endmodule

### bench/tb_gaussian_psf_value_and_gradient_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the Gaussian PSF value and gradient unit
// Streams pixel coordinates under several register settings and idle
// patterns, predicts every result word in fixed point and compares fields.
// ----------------------------------------------------------------------------
module tb_gaussian_psf_value_and_gradient_unit;
    import gpsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [CfgIdxW-1:0] cfg_wr_index;
    logic [31:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [15:0]        s_pixel_col;
    logic [15:0]        s_pixel_row;
    logic               m_valid;
    logic               m_ready;
    logic [31:0]        m_model_value;
    logic [16:0]        m_deriv_amplitude;
    logic [31:0]        m_deriv_center_x;
    logic [31:0]        m_deriv_center_y;
    logic [31:0]        m_deriv_sigma;
    logic               m_saturated;

    gaussian_psf_value_and_gradient_unit dut (.*);

    // Local copy of the registers, updated on every write
    logic [31:0] bg_reg;
    logic [31:0] amp_reg;
    logic [23:0] cx_reg;
    logic [23:0] cy_reg;
    logic [15:0] sig_reg;

    // exp(-2^(b-16)) table in Q0.30, built at time zero
    logic [63:0] exp_tab [ExpBits];

    res_t   pending_results [$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     fail_count;
    int     words_sent;
    int     words_checked;
    int     settings_run;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [63:0] series_exp_q30(input logic [63:0] x);
        logic signed [63:0] sum;
        logic [63:0]        term;
        sum  = 64'sh100_0000_0000;
        term = 64'h100_0000_0000;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * x) >> 16) / 64'(n);
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        return (64'(sum) + 64'd512) >> 10;
    endfunction

    // Clamp a signed magnitude to 32 bits, raising the flag if clamped
    function automatic logic [31:0] clamp32(input logic neg, input logic [127:0] mag,
                                           inout logic flag);
        if (!neg) begin
            if (mag > 128'h7FFF_FFFF) begin
                flag = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return mag[31:0];
        end
        if (mag > 128'h8000_0000) begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return 32'(-mag[31:0]);
    endfunction

    function automatic res_t predict_psf(input logic [15:0] col, input logic [15:0] row);
        res_t               r;
        logic signed [63:0] bgv;
        logic signed [63:0] ampv;
        logic signed [63:0] v;
        logic               aneg;
        logic               dxneg;
        logic               dyneg;
        logic               flag;
        logic [63:0]        am;
        logic [63:0]        s;
        logic [63:0]        dxm;
        logic [63:0]        dym;
        logic [63:0]        d2;
        logic [63:0]        r2;
        logic [63:0]        t;
        logic [127:0]       acc;
        logic [127:0]       pm;
        logic [127:0]       mag;
        bgv  = 64'($signed(bg_reg));
        ampv = 64'($signed(amp_reg));
        aneg = ampv < 0;
        am   = aneg ? 64'(-ampv) : 64'(ampv);
        s    = (sig_reg == 0) ? 64'd1 : 64'(sig_reg);
        flag = 1'b0;
        dxneg = ({col, 8'h00} < cx_reg);
        dxm   = dxneg ? 64'(cx_reg) - 64'({col, 8'h00}) : 64'({col, 8'h00}) - 64'(cx_reg);
        dyneg = ({row, 8'h00} < cy_reg);
        dym   = dyneg ? 64'(cy_reg) - 64'({row, 8'h00}) : 64'({row, 8'h00}) - 64'(cy_reg);
        d2 = dxm * dxm + dym * dym;
        r2 = s * s;
        t   = 0;
        acc = 0;
        if (d2 < 24 * r2) begin
            t   = ((d2 << 16) + r2) / (2 * r2);
            acc = 128'd1 << 30;
            for (int b = 0; b < ExpBits; b++) begin
                if (t[b]) begin
                    acc = (acc * exp_tab[b] + (128'd1 << 29)) >> 30;
                end
            end
        end
        pm = (128'(am) * acc + (128'd1 << 29)) >> 30;
        v  = bgv + (aneg ? -64'(pm) : 64'(pm));
        if (v >= 0) begin
            r.model_value = clamp32(1'b0, 128'(v), flag);
        end else begin
            r.model_value = clamp32(1'b1, 128'(-v), flag);
        end
        r.deriv_amplitude = 17'((acc + (128'd1 << 13)) >> 14);
        mag = (pm * dxm * 256 + r2 / 2) / r2;
        r.deriv_center_x = clamp32(aneg != dxneg, mag, flag);
        mag = (pm * dym * 256 + r2 / 2) / r2;
        r.deriv_center_y = clamp32(aneg != dyneg, mag, flag);
        mag = (pm * 2 * t + s * 128) / (s * 256);
        r.deriv_sigma = clamp32(aneg, mag, flag);
        r.saturated = flag;
        return r;
    endfunction

    // Drive one register write; only called while the unit is idle
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_BACKGROUND: bg_reg  = data;
            CFG_AMPLITUDE:  amp_reg = data;
            CFG_CENTER_X:   cx_reg  = data[23:0];
            CFG_CENTER_Y:   cy_reg  = data[23:0];
            CFG_SIGMA:      sig_reg = data[15:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [31:0] bg, input logic [31:0] amp,
                                input logic [23:0] cx, input logic [23:0] cy,
                                input logic [15:0] sig);
        write_reg(CFG_BACKGROUND, bg);
        write_reg(CFG_AMPLITUDE, amp);
        write_reg(CFG_CENTER_X, {8'h00, cx});
        write_reg(CFG_CENTER_Y, {8'h00, cy});
        write_reg(CFG_SIGMA, {16'h0000, sig});
        settings_run++;
    endtask

    // Send one pixel word; queue its prediction at the accepting edge.
    // Valid stays high after the accept so words can go back to back;
    // idle cycles and drain_results drop it.
    task automatic send_pixel(input logic [15:0] col, input logic [15:0] row);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_pixel_col <= col;
        s_pixel_row <= row;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_results.push_back(predict_psf(col, row));
        words_sent++;
    endtask

    // Wait until every expected word has come back, then let the pipe drain
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (100) @(posedge aclk);
    endtask

    // Pixel near the centre most of the time so the exp term is nonzero
    task automatic send_near_pixel(input int spread);
        int col;
        int row;
        col = int'(cx_reg >> 8) + $urandom_range(2 * spread) - spread;
        row = int'(cy_reg >> 8) + $urandom_range(2 * spread) - spread;
        send_pixel(16'(col), 16'(row));
    endtask

    task automatic test_directed();
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'h0001, 16'h0000);
        send_pixel(16'h0000, 16'h0001);
        send_pixel(16'h0002, 16'h0003);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF);
        send_pixel(16'hAAAA, 16'h5555);
        drain_results();
        // sigma of zero behaves as the smallest radius; small offset center
        load_setting(32'h0000_0000, 32'h0001_0000, 24'h000080, 24'h000040, 16'h0000);
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'h0001, 16'h0000);
        drain_results();
        // extreme registers: saturate value and gradients
        load_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'hFF00, 16'hFF80);
        send_pixel(16'h0000, 16'h0000);
        drain_results();
        load_setting(32'h8000_0000, 32'h8000_0000, 24'h000000, 24'hFFFFFF, 16'h0001);
        send_pixel(16'h0000, 16'hFFFF);
        send_pixel(16'h0000, 16'hFFFE);
        send_pixel(16'h5555, 16'hAAAA);
        drain_results();
        // unknown register index must leave everything untouched
        write_reg(3'd5, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h1234_5678);
        load_setting(32'h8000_0000, 32'h8000_0000, 24'h000200, 24'h000300, 16'h4000);
        send_pixel(16'h0002, 16'h0003);
        send_pixel(16'h0010, 16'h0020);
        send_pixel(16'h0042, 16'h0003);
        drain_results();
    endtask

    // One random register setting followed by a burst of pixels
    task automatic test_random_setting(input int words);
        logic [15:0] sig;
        case ($urandom_range(3))
            0: sig = 16'($urandom_range(1, 255));
            1: sig = 16'($urandom_range(256, 2047));
            2: sig = 16'($urandom);
            default: sig = 16'($urandom_range(0, 4));
        endcase
        load_setting($urandom, $urandom, 24'($urandom), 24'($urandom), sig);
        for (int i = 0; i < words; i++) begin
            if ($urandom_range(9) < 8) begin
                send_near_pixel(int'(sig >> 8) * 5 + 2);
            end else begin
                send_pixel(16'($urandom), 16'($urandom));
            end
        end
        drain_results();
    endtask

    task automatic test_idle_phase(input int idle_pct, input int stall_pct, input int sets);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < sets; k++) begin
            test_random_setting($urandom_range(30, 60));
        end
    endtask

    // Hold off the sender until the pipe is empty, then resume
    task automatic test_sender_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        for (int i = 0; i < 10; i++) begin
            send_near_pixel(8);
        end
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        for (int i = 0; i < 10; i++) begin
            send_near_pixel(8);
        end
        drain_results();
    endtask

    // Result side: random stalls, compare each accepted word field by field
    always @(posedge aclk) begin
        res_t exp_w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result word");
                    fail_count++;
                end else begin
                    exp_w = pending_results.pop_front();
                    words_checked++;
                    if (m_model_value !== exp_w.model_value) begin
                        $error("model_value exp %h got %h", exp_w.model_value,
                               m_model_value);
                        fail_count++;
                    end
                    if (m_deriv_amplitude !== exp_w.deriv_amplitude) begin
                        $error("deriv_amplitude exp %h got %h", exp_w.deriv_amplitude,
                               m_deriv_amplitude);
                        fail_count++;
                    end
                    if (m_deriv_center_x !== exp_w.deriv_center_x) begin
                        $error("deriv_center_x exp %h got %h", exp_w.deriv_center_x,
                               m_deriv_center_x);
                        fail_count++;
                    end
                    if (m_deriv_center_y !== exp_w.deriv_center_y) begin
                        $error("deriv_center_y exp %h got %h", exp_w.deriv_center_y,
                               m_deriv_center_y);
                        fail_count++;
                    end
                    if (m_deriv_sigma !== exp_w.deriv_sigma) begin
                        $error("deriv_sigma exp %h got %h", exp_w.deriv_sigma,
                               m_deriv_sigma);
                        fail_count++;
                    end
                    if (m_saturated !== exp_w.saturated) begin
                        $error("saturated exp %b got %b", exp_w.saturated, m_saturated);
                        fail_count++;
                    end
                end
            end
            m_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_index   = '0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_pixel_col    = '0;
        s_pixel_row    = '0;
        fail_count     = 0;
        words_sent     = 0;
        words_checked  = 0;
        settings_run   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bg_reg  = 32'h0;
        amp_reg = AMPLITUDE_RESET;
        cx_reg  = 24'h0;
        cy_reg  = 24'h0;
        sig_reg = SIGMA_RESET;
        for (int b = 0; b < ExpBits; b++) begin
            exp_tab[b] = (b <= 16) ? series_exp_q30(64'd1 << b)
                                   : (exp_tab[b-1] * exp_tab[b-1] + (64'd1 << 29)) >> 30;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_idle_phase(0, 0, 6);
        test_idle_phase(52, 0, 5);
        test_idle_phase(0, 52, 5);
        test_idle_phase(17, 17, 6);
        test_sender_holdoff();
        // close on one more random setting with far and near pixels
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_setting(20);

        $display("Covered %0d pixel words under %0d register settings, %0d results checked",
                 words_sent, settings_run, words_checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
